FILE: design/tcq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the terminal colour quantizer.
package tcq_pkg;

    localparam logic [1:0] DEPTH_MONO    = 2'd0;
    localparam logic [1:0] DEPTH_SIXTEEN = 2'd1;
    localparam logic [1:0] DEPTH_INDEXED = 2'd2;
    localparam logic [1:0] DEPTH_TRUE    = 2'd3;

    localparam logic ACT_COLOUR = 1'b0;
    localparam logic ACT_FORGET = 1'b1;

    // luminance = (299 r + 587 g + 114 b) / 1000
    localparam logic [9:0]  LUM_COEF_R = 10'd299;
    localparam logic [9:0]  LUM_COEF_G = 10'd587;
    localparam logic [9:0]  LUM_COEF_B = 10'd114;
    // floor(x / 1000) = (x * 268436) >> 28 for x < 2^18
    localparam logic [18:0] LUM_RECIP  = 19'd268436;
    localparam int          LUM_SHIFT  = 28;
    // floor(x / 10) = (x * 205) >> 11 for x < 1024
    localparam logic [15:0] STEP_RECIP = 16'd205;
    localparam int          STEP_SHIFT = 11;

    localparam logic [7:0] GREY_OFFSET    = 8'd8;
    localparam logic [7:0] GREY_STRIDE    = 8'd10;
    localparam logic [4:0] GREY_STEP_MAX  = 5'd23;
    localparam logic [7:0] GREY_BASE_CODE = 8'd232;
    localparam logic [7:0] CUBE_BASE_CODE = 8'd16;
    localparam logic [7:0] CUBE_R_STRIDE  = 8'd36;
    localparam logic [7:0] CUBE_G_STRIDE  = 8'd6;
    localparam logic [3:0] ANSI_LAST      = 4'd15;

    typedef struct packed {
        logic       emit;
        logic [1:0] depth;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_cell_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] sgr;
    } t_ansi_entry;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LEVEL,
        BK_LUM,
        BK_STEP,
        BK_GREY,
        BK_ANSI,
        BK_DONE
    } t_back_state;

    // nearest of 0,95,135,175,215,255; lower level wins a tie
    function automatic logic [2:0] closest_level(input logic [7:0] v);
        logic [2:0] idx;
        if (v <= 8'd47) begin
            idx = 3'd0;
        end else if (v <= 8'd115) begin
            idx = 3'd1;
        end else if (v <= 8'd155) begin
            idx = 3'd2;
        end else if (v <= 8'd195) begin
            idx = 3'd3;
        end else if (v <= 8'd235) begin
            idx = 3'd4;
        end else begin
            idx = 3'd5;
        end
        return idx;
    endfunction

    function automatic logic [7:0] cube_level(input logic [2:0] idx);
        logic [7:0] lvl;
        case (idx)
            3'd0:    lvl = 8'd0;
            3'd1:    lvl = 8'd95;
            3'd2:    lvl = 8'd135;
            3'd3:    lvl = 8'd175;
            3'd4:    lvl = 8'd215;
            3'd5:    lvl = 8'd255;
            default: lvl = 8'd0;
        endcase
        return lvl;
    endfunction

    function automatic logic [15:0] diff_sq(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return {8'd0, d} * {8'd0, d};
    endfunction

    function automatic logic [17:0] sq_err(
        input logic [7:0] r1, input logic [7:0] g1, input logic [7:0] b1,
        input logic [7:0] r2, input logic [7:0] g2, input logic [7:0] b2
    );
        return 18'(diff_sq(r1, r2)) + 18'(diff_sq(g1, g2)) + 18'(diff_sq(b1, b2));
    endfunction

    function automatic t_ansi_entry ansi_entry(input logic [3:0] idx);
        t_ansi_entry e;
        case (idx)
            4'd0:    e = '{8'd0,   8'd0,   8'd0,   8'd30};
            4'd1:    e = '{8'd205, 8'd0,   8'd0,   8'd31};
            4'd2:    e = '{8'd0,   8'd205, 8'd0,   8'd32};
            4'd3:    e = '{8'd205, 8'd205, 8'd0,   8'd33};
            4'd4:    e = '{8'd0,   8'd0,   8'd238, 8'd34};
            4'd5:    e = '{8'd205, 8'd0,   8'd205, 8'd35};
            4'd6:    e = '{8'd0,   8'd205, 8'd205, 8'd36};
            4'd7:    e = '{8'd229, 8'd229, 8'd229, 8'd37};
            4'd8:    e = '{8'd127, 8'd127, 8'd127, 8'd90};
            4'd9:    e = '{8'd255, 8'd0,   8'd0,   8'd91};
            4'd10:   e = '{8'd0,   8'd255, 8'd0,   8'd92};
            4'd11:   e = '{8'd255, 8'd255, 8'd0,   8'd93};
            4'd12:   e = '{8'd92,  8'd92,  8'd255, 8'd94};
            4'd13:   e = '{8'd255, 8'd0,   8'd255, 8'd95};
            4'd14:   e = '{8'd0,   8'd255, 8'd255, 8'd96};
            4'd15:   e = '{8'd255, 8'd255, 8'd255, 8'd97};
            default: e = '{8'd0,   8'd0,   8'd0,   8'd30};
        endcase
        return e;
    endfunction

endpackage

FILE: design/tcq_front.sv
`timescale 1ns / 1ps
// Front end: input handshake, depth register, repeat suppression and forget handling.
module tcq_front import tcq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_colour_depth,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_cell_word o_word
);

    logic [1:0] r_depth;
    logic       r_known;
    logic [7:0] r_last_red;
    logic [7:0] r_last_green;
    logic [7:0] r_last_blue;
    logic       n_known;

    logic       w_accept;
    logic       w_repeat;
    logic       w_emit;

    assign o_stall     = i_queue_full;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && !i_queue_full;

    assign w_repeat = r_known && (i_red == r_last_red) && (i_green == r_last_green)
                      && (i_blue == r_last_blue);
    assign w_emit   = (i_action == ACT_COLOUR) && (r_depth != DEPTH_MONO) && !w_repeat;

    assign o_push       = w_accept;
    assign o_word.emit  = w_emit;
    assign o_word.depth = r_depth;
    assign o_word.red   = i_red;
    assign o_word.green = i_green;
    assign o_word.blue  = i_blue;

    always_comb begin
        n_known = r_known;
        if (w_accept && i_action == ACT_FORGET) begin
            n_known = 1'b0;
        end else if (w_accept && w_emit) begin
            n_known = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= DEPTH_INDEXED;
            r_known      <= 1'b0;
            r_last_red   <= 8'd0;
            r_last_green <= 8'd0;
            r_last_blue  <= 8'd0;
        end else begin
            r_known <= n_known;
            if (i_cfg_valid && o_cfg_ready) begin
                r_depth <= i_cfg_colour_depth;
            end
            if (w_accept && w_emit) begin
                r_last_red   <= i_red;
                r_last_green <= i_green;
                r_last_blue  <= i_blue;
            end
        end
    end

    a_forget_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == ACT_FORGET) |=> !r_known)
        else $error("remembered colour survived a forget");

endmodule

FILE: design/tcq_queue.sv
`timescale 1ns / 1ps
// Short register queue of classified words between front and back.
module tcq_queue import tcq_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cell_word i_word,
    output logic       o_full,
    input  logic       i_pop,
    output t_cell_word o_word,
    output logic       o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cell_word         r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_word  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

endmodule

FILE: design/tcq_back.sv
`timescale 1ns / 1ps
// Back end: palette search sequencer and output register.
module tcq_back import tcq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cell_word i_word,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_emit_colour,
    output logic [7:0] o_colour_code,
    output logic [7:0] o_sent_red,
    output logic [7:0] o_sent_green,
    output logic [7:0] o_sent_blue
);

    t_back_state r_state;
    t_back_state n_state;

    t_cell_word  r_w;
    logic [2:0]  r_cr;
    logic [2:0]  r_cg;
    logic [2:0]  r_cb;
    logic [17:0] r_lum_num;
    logic [7:0]  r_lum;
    logic [17:0] r_cube_err;
    logic [4:0]  r_step;
    logic [3:0]  r_idx;
    logic [17:0] r_best_d;
    logic [7:0]  r_code;

    logic        r_out_valid;
    logic        r_out_emit;
    logic [7:0]  r_out_code;
    logic [7:0]  r_out_red;
    logic [7:0]  r_out_green;
    logic [7:0]  r_out_blue;

    logic        w_out_free;
    logic        w_pop;
    logic        w_load;
    logic        w_true;

    logic [36:0] w_lum_prod;
    logic [7:0]  w_lum_off;
    logic [15:0] w_step_prod;
    logic [4:0]  w_step_raw;
    logic [4:0]  w_step;
    logic [7:0]  w_grey;
    logic [17:0] w_grey_err;
    logic [17:0] w_cube_err;
    logic [7:0]  w_cube_code;
    t_ansi_entry w_ansi;
    logic [17:0] w_ansi_d;

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    if (i_word.emit && i_word.depth == DEPTH_INDEXED) begin
                        n_state = BK_LEVEL;
                    end else if (i_word.emit && i_word.depth == DEPTH_SIXTEEN) begin
                        n_state = BK_ANSI;
                    end else begin
                        n_state = BK_DONE;
                    end
                end
            end
            BK_LEVEL: n_state = BK_LUM;
            BK_LUM:   n_state = BK_STEP;
            BK_STEP:  n_state = BK_GREY;
            BK_GREY:  n_state = BK_DONE;
            BK_ANSI: begin
                if (r_idx == ANSI_LAST) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        w_pop  = 1'b0;
        w_load = 1'b0;
        case (r_state)
            BK_IDLE: w_pop  = !i_empty;
            BK_DONE: w_load = w_out_free;
            default: begin
                w_pop  = 1'b0;
                w_load = 1'b0;
            end
        endcase
    end

    assign o_pop = w_pop;

    // 256 colour datapath
    assign w_lum_prod  = 37'(r_lum_num) * 37'(LUM_RECIP);
    assign w_cube_err  = sq_err(r_w.red, r_w.green, r_w.blue,
                                cube_level(r_cr), cube_level(r_cg), cube_level(r_cb));
    assign w_lum_off   = r_lum - GREY_OFFSET;
    assign w_step_prod = {8'd0, w_lum_off} * STEP_RECIP;
    assign w_step_raw  = w_step_prod[STEP_SHIFT +: 5];
    assign w_step      = (r_lum < GREY_OFFSET) ? 5'd0 :
                         (w_step_raw > GREY_STEP_MAX) ? GREY_STEP_MAX : w_step_raw;
    assign w_grey      = GREY_OFFSET + 8'(r_step) * GREY_STRIDE;
    assign w_grey_err  = sq_err(r_w.red, r_w.green, r_w.blue, w_grey, w_grey, w_grey);
    assign w_cube_code = CUBE_BASE_CODE + 8'(r_cr) * CUBE_R_STRIDE
                         + 8'(r_cg) * CUBE_G_STRIDE + 8'(r_cb);

    // 16 colour datapath
    assign w_ansi   = ansi_entry(r_idx);
    assign w_ansi_d = sq_err(r_w.red, r_w.green, r_w.blue,
                             w_ansi.red, w_ansi.green, w_ansi.blue);

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_w    <= i_word;
            r_code <= 8'd0;
            r_idx  <= 4'd0;
        end
        case (r_state)
            BK_LEVEL: begin
                r_cr      <= closest_level(r_w.red);
                r_cg      <= closest_level(r_w.green);
                r_cb      <= closest_level(r_w.blue);
                r_lum_num <= 18'(r_w.red) * 18'(LUM_COEF_R)
                             + 18'(r_w.green) * 18'(LUM_COEF_G)
                             + 18'(r_w.blue) * 18'(LUM_COEF_B);
            end
            BK_LUM: begin
                r_lum      <= w_lum_prod[LUM_SHIFT +: 8];
                r_cube_err <= w_cube_err;
            end
            BK_STEP: begin
                r_step <= w_step;
            end
            BK_GREY: begin
                r_code <= (w_grey_err < r_cube_err) ? GREY_BASE_CODE + 8'(r_step)
                                                    : w_cube_code;
            end
            BK_ANSI: begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == 4'd0 || w_ansi_d < r_best_d) begin
                    r_best_d <= w_ansi_d;
                    r_code   <= w_ansi.sgr;
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_true = r_w.emit && (r_w.depth == DEPTH_TRUE);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_emit  <= r_w.emit;
            r_out_code  <= r_code;
            r_out_red   <= w_true ? r_w.red   : 8'd0;
            r_out_green <= w_true ? r_w.green : 8'd0;
            r_out_blue  <= w_true ? r_w.blue  : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_emit_colour = r_out_emit;
    assign o_colour_code = r_out_code;
    assign o_sent_red    = r_out_red;
    assign o_sent_green  = r_out_green;
    assign o_sent_blue   = r_out_blue;

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_emit) |->
        (r_out_code == 8'd0 && r_out_red == 8'd0 && r_out_green == 8'd0
         && r_out_blue == 8'd0))
        else $error("suppressed word carries colour data");

    a_ansi_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_ANSI) |-> (r_w.emit && r_w.depth == DEPTH_SIXTEEN))
        else $error("16 colour search on a word of another depth");

endmodule

FILE: design/terminal_colour_quantizer_unit.sv
`timescale 1ns / 1ps
// Top level of the terminal colour quantizer: front end, word queue and back end.
//
// Input channel (i_valid / o_stall) takes one word per cell: an action bit and an
// RGB888 colour. Output channel (o_valid / i_stall) gives one word per input word:
// emit flag, colour code and the RGB to send in true colour mode.
// The depth register is written over i_cfg_valid / o_cfg_ready; ready is always high.
// The front end decides suppression in the accept cycle and pushes into a queue of
// QUEUE_DEPTH words; the back end drains it one word at a time.
// Back end work per word: no palette search for silent, forget and true colour words;
// in 256 mode it steps through level pick, luminance, grey step and compare; in 16
// mode it tries one palette entry per cycle over 16 entries.
// Sustained rate is set by the back end sequencer.
// A stalled output holds its word; the queue keeps taking input until it fills,
// then o_stall rises. Reset (synchronous, active low) empties the queue and output,
// sets depth to 256 colours and forgets the last colour sent.
module terminal_colour_quantizer_unit import tcq_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_emit_colour,
    output logic [7:0] o_colour_code,
    output logic [7:0] o_sent_red,
    output logic [7:0] o_sent_green,
    output logic [7:0] o_sent_blue,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_colour_depth
);

    t_cell_word w_push_word;
    t_cell_word w_pop_word;
    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;

    tcq_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_red              (i_red),
        .i_green            (i_green),
        .i_blue             (i_blue),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_colour_depth (i_cfg_colour_depth),
        .i_queue_full       (w_full),
        .o_push             (w_push),
        .o_word             (w_push_word)
    );

    tcq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_push_word),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_word  (w_pop_word),
        .o_empty (w_empty)
    );

    tcq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_word        (w_pop_word),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_emit_colour (o_emit_colour),
        .o_colour_code (o_colour_code),
        .o_sent_red    (o_sent_red),
        .o_sent_green  (o_sent_green),
        .o_sent_blue   (o_sent_blue)
    );

endmodule

FILE: dv/tb_terminal_colour_quantizer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the terminal colour quantizer: directed, backpressure, random.
module tb_terminal_colour_quantizer_unit;
    import tcq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 200;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 225;

    typedef struct {
        logic       emit;
        logic [7:0] code;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_cell_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic       i_action;
    logic [7:0] i_red;
    logic [7:0] i_green;
    logic [7:0] i_blue;
    logic       o_valid;
    logic       i_stall;
    logic       o_emit_colour;
    logic [7:0] o_colour_code;
    logic [7:0] o_sent_red;
    logic [7:0] o_sent_green;
    logic [7:0] o_sent_blue;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_colour_depth;

    terminal_colour_quantizer_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_red              (i_red),
        .i_green            (i_green),
        .i_blue             (i_blue),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_emit_colour      (o_emit_colour),
        .o_colour_code      (o_colour_code),
        .o_sent_red         (o_sent_red),
        .o_sent_green       (o_sent_green),
        .o_sent_blue        (o_sent_blue),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_colour_depth (i_cfg_colour_depth)
    );

    // predictor state
    logic [1:0] depth_model;
    logic       colour_known;
    logic [7:0] last_red;
    logic [7:0] last_green;
    logic [7:0] last_blue;

    t_cell_result expected_cells[$];
    int           mismatches;
    int           tx_gap_max;
    int           rx_stall_max;
    bit           hold_request;
    int           idle_cycles;
    logic [7:0]   prev_red;
    logic [7:0]   prev_green;
    logic [7:0]   prev_blue;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int level_value(input int idx);
        case (idx)
            0:       return 0;
            1:       return 95;
            2:       return 135;
            3:       return 175;
            4:       return 215;
            default: return 255;
        endcase
    endfunction

    // {red, green, blue, sgr}
    function automatic logic [31:0] ansi16_colour(input int idx);
        case (idx)
            0:       return {8'd0,   8'd0,   8'd0,   8'd30};
            1:       return {8'd205, 8'd0,   8'd0,   8'd31};
            2:       return {8'd0,   8'd205, 8'd0,   8'd32};
            3:       return {8'd205, 8'd205, 8'd0,   8'd33};
            4:       return {8'd0,   8'd0,   8'd238, 8'd34};
            5:       return {8'd205, 8'd0,   8'd205, 8'd35};
            6:       return {8'd0,   8'd205, 8'd205, 8'd36};
            7:       return {8'd229, 8'd229, 8'd229, 8'd37};
            8:       return {8'd127, 8'd127, 8'd127, 8'd90};
            9:       return {8'd255, 8'd0,   8'd0,   8'd91};
            10:      return {8'd0,   8'd255, 8'd0,   8'd92};
            11:      return {8'd255, 8'd255, 8'd0,   8'd93};
            12:      return {8'd92,  8'd92,  8'd255, 8'd94};
            13:      return {8'd255, 8'd0,   8'd255, 8'd95};
            14:      return {8'd0,   8'd255, 8'd255, 8'd96};
            default: return {8'd255, 8'd255, 8'd255, 8'd97};
        endcase
    endfunction

    function automatic int dist_sq(input int r1, input int g1, input int b1,
                                   input int r2, input int g2, input int b2);
        return (r1 - r2) * (r1 - r2) + (g1 - g2) * (g1 - g2) + (b1 - b2) * (b1 - b2);
    endfunction

    function automatic int nearest_level(input int v);
        int best;
        int best_d;
        int d;
        best   = 0;
        best_d = 32'h7fffffff;
        for (int i = 0; i < 6; i++) begin
            d = (v - level_value(i)) * (v - level_value(i));
            if (d < best_d) begin
                best_d = d;
                best   = i;
            end
        end
        return best;
    endfunction

    function automatic logic [7:0] xterm256_code(input int r, input int g, input int b);
        int cr;
        int cg;
        int cb;
        int cube_err;
        int lum;
        int step;
        int grey;
        cr = nearest_level(r);
        cg = nearest_level(g);
        cb = nearest_level(b);
        cube_err = dist_sq(r, g, b, level_value(cr), level_value(cg), level_value(cb));
        lum  = (r * 299 + g * 587 + b * 114) / 1000;
        step = (lum < 8) ? 0 : (lum - 8) / 10;
        if (step > 23) step = 23;
        grey = 8 + step * 10;
        if (dist_sq(r, g, b, grey, grey, grey) < cube_err) return 8'(232 + step);
        return 8'(16 + 36 * cr + 6 * cg + cb);
    endfunction

    function automatic logic [7:0] ansi16_sgr(input int r, input int g, input int b);
        logic [31:0] e;
        logic [7:0]  best;
        int          best_d;
        int          d;
        best   = 8'd30;
        best_d = 32'h7fffffff;
        for (int i = 0; i < 16; i++) begin
            e = ansi16_colour(i);
            d = dist_sq(r, g, b, int'(e[31:24]), int'(e[23:16]), int'(e[15:8]));
            if (d < best_d) begin
                best_d = d;
                best   = e[7:0];
            end
        end
        return best;
    endfunction

    function automatic t_cell_result quantize_cell(input logic act, input logic [7:0] r,
                                                   input logic [7:0] g, input logic [7:0] b);
        t_cell_result res;
        res = '{1'b0, 8'd0, 8'd0, 8'd0, 8'd0};
        if (act == ACT_FORGET) begin
            colour_known = 1'b0;
            return res;
        end
        if (depth_model == DEPTH_MONO) return res;
        if (colour_known && r == last_red && g == last_green && b == last_blue) return res;
        res.emit = 1'b1;
        case (depth_model)
            DEPTH_TRUE: begin
                res.red   = r;
                res.green = g;
                res.blue  = b;
            end
            DEPTH_INDEXED: res.code = xterm256_code(int'(r), int'(g), int'(b));
            default:       res.code = ansi16_sgr(int'(r), int'(g), int'(b));
        endcase
        colour_known = 1'b1;
        last_red     = r;
        last_green   = g;
        last_blue    = b;
        return res;
    endfunction

    task automatic send_cell(input logic act, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_red    <= r;
        i_green  <= g;
        i_blue   <= b;
        do @(posedge i_clk); while (o_stall);
        expected_cells.push_back(quantize_cell(act, r, g, b));
        if (act == ACT_COLOUR) begin
            prev_red   = r;
            prev_green = g;
            prev_blue  = b;
        end
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_depth(input logic [1:0] d);
        drain_and_settle();
        i_cfg_valid        <= 1'b1;
        i_cfg_colour_depth <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        depth_model = d;
    endtask

    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            1: begin
                // straddle the cube level decision points
                case ($urandom_range(0, 4))
                    0:       return 8'(47 + $urandom_range(0, 1));
                    1:       return 8'(115 + $urandom_range(0, 1));
                    2:       return 8'(155 + $urandom_range(0, 1));
                    3:       return 8'(195 + $urandom_range(0, 1));
                    default: return 8'(235 + $urandom_range(0, 1));
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_reset_depth();
        send_cell(ACT_COLOUR, 8'd0, 8'd0, 8'd0);
        send_cell(ACT_COLOUR, 8'd0, 8'd0, 8'd0);
        send_cell(ACT_COLOUR, 8'd255, 8'd255, 8'd255);
        send_cell(ACT_COLOUR, 8'd128, 8'd128, 8'd128);
        send_cell(ACT_COLOUR, 8'd8, 8'd8, 8'd8);
        send_cell(ACT_FORGET, 8'd255, 8'd255, 8'd255);
        send_cell(ACT_COLOUR, 8'd8, 8'd8, 8'd8);
    endtask

    task automatic test_sixteen_colours();
        write_depth(DEPTH_SIXTEEN);
        send_cell(ACT_COLOUR, 8'd205, 8'd0, 8'd0);
        send_cell(ACT_COLOUR, 8'd127, 8'd127, 8'd127);
        send_cell(ACT_COLOUR, 8'd92, 8'd92, 8'd255);
        send_cell(ACT_COLOUR, 8'd255, 8'd255, 8'd255);
        send_cell(ACT_COLOUR, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_true_colour();
        write_depth(DEPTH_TRUE);
        send_cell(ACT_COLOUR, 8'd255, 8'd0, 8'd128);
        send_cell(ACT_COLOUR, 8'd255, 8'd0, 8'd128);
        send_cell(ACT_COLOUR, 8'd0, 8'd255, 8'd1);
    endtask

    // remembered colour must survive depth changes
    task automatic test_mono_and_depth_change();
        write_depth(DEPTH_MONO);
        send_cell(ACT_COLOUR, 8'd1, 8'd2, 8'd3);
        write_depth(DEPTH_INDEXED);
        send_cell(ACT_COLOUR, 8'd0, 8'd255, 8'd1);
        send_cell(ACT_COLOUR, 8'd1, 8'd2, 8'd3);
    endtask

    task automatic test_backpressure();
        tx_gap_max   = 0;
        hold_request = 1'b1;
        for (int i = 0; i < 20; i++)
            send_cell(ACT_COLOUR, random_channel(), random_channel(), random_channel());
        drain_and_settle();
    endtask

    task automatic test_random_cells();
        int kind;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0:       write_depth(DEPTH_INDEXED);
                1:       write_depth(DEPTH_SIXTEEN);
                2:       write_depth(DEPTH_TRUE);
                default: write_depth(phase == 3 ? DEPTH_MONO : 2'($urandom_range(0, 3)));
            endcase
            tx_gap_max   = (phase & 1) ? 14 : 0;
            rx_stall_max = (phase & 2) ? 14 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                kind = $urandom_range(0, 99);
                if (kind < 5)
                    send_cell(ACT_FORGET, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                else if (kind < 30)
                    send_cell(ACT_COLOUR, prev_red, prev_green, prev_blue);
                else
                    send_cell(ACT_COLOUR, random_channel(), random_channel(), random_channel());
            end
        end
    endtask

    // result checker
    initial begin
        t_cell_result exp_cell;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            int wait_cycles;
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                wait_cycles = $urandom_range(0, rx_stall_max);
                if (wait_cycles > 0) begin
                    i_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            if (expected_cells.size() == 0) begin
                $error("unexpected result word: emit_colour %0d colour_code %0d",
                       o_emit_colour, o_colour_code);
                mismatches++;
            end else begin
                exp_cell = expected_cells.pop_front();
                if (o_emit_colour !== exp_cell.emit) begin
                    $error("emit_colour: expected %0d, got %0d", exp_cell.emit, o_emit_colour);
                    mismatches++;
                end
                if (o_colour_code !== exp_cell.code) begin
                    $error("colour_code: expected %0d, got %0d", exp_cell.code, o_colour_code);
                    mismatches++;
                end
                if (o_sent_red !== exp_cell.red) begin
                    $error("sent_red: expected %0d, got %0d", exp_cell.red, o_sent_red);
                    mismatches++;
                end
                if (o_sent_green !== exp_cell.green) begin
                    $error("sent_green: expected %0d, got %0d", exp_cell.green, o_sent_green);
                    mismatches++;
                end
                if (o_sent_blue !== exp_cell.blue) begin
                    $error("sent_blue: expected %0d, got %0d", exp_cell.blue, o_sent_blue);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_terminal_colour_quantizer_unit failed");
            $finish;
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_action           <= ACT_COLOUR;
        i_red              <= 8'd0;
        i_green            <= 8'd0;
        i_blue             <= 8'd0;
        i_cfg_valid        <= 1'b0;
        i_cfg_colour_depth <= DEPTH_INDEXED;
        idle_cycles        = 0;
        mismatches         = 0;
        hold_request       = 1'b0;
        tx_gap_max         = 14;
        rx_stall_max       = 14;
        depth_model        = DEPTH_INDEXED;
        colour_known       = 1'b0;
        last_red           = 8'd0;
        last_green         = 8'd0;
        last_blue          = 8'd0;
        prev_red           = 8'd0;
        prev_green         = 8'd0;
        prev_blue          = 8'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_depth();
        test_sixteen_colours();
        test_true_colour();
        test_mono_and_depth_change();
        test_backpressure();
        test_random_cells();

        drain_and_settle();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_terminal_colour_quantizer_unit passed");
        end else begin
            $display("tb_terminal_colour_quantizer_unit failed");
        end
        $finish;
    end

endmodule
